### rtl/ecst_pkg.sv
// Shared types and constants for the error code suppression table.
// No dependencies; imported by error_code_suppression_table.
package ecst_pkg;

  // Default table depth and field widths
  localparam int unsigned CodeSlotsDefault = 16;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned DataW   = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned KindW   = 2;

  // Stream widths: payload packed from bit 0, padded to whole bytes
  localparam int unsigned InPackW  = CodeW + DataW + 2;
  localparam int unsigned InTdataW = ((InPackW + 7) / 8) * 8;
  localparam int unsigned OutPackW  = CodeW + DataW + 3;
  localparam int unsigned OutTdataW = ((OutPackW + 7) / 8) * 8;

  localparam logic [WindowW-1:0] WindowReset = WindowW'(60);

  // Request kinds; the remaining code is reserved and does nothing
  typedef enum logic [KindW-1:0] {
    KIND_REPORT = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // One registered input request
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CodeW-1:0] code;
    logic [DataW-1:0] data;
    logic             raised;
    logic             force_emit;
  } in_req_t;

  // One result
  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] code;
    logic [DataW-1:0] data;
    logic             suppressed;
    logic             table_full;
  } out_res_t;

endpackage

### rtl/error_code_suppression_table.sv
// Keyed error-report filter: seconds counter plus an associative code table.
// Depends on ecst_pkg (types, widths, reset constants).
// Input stream (s_axis_*): one request per handshake. tuser carries the kind
//   (report, one-second tick, clear table). tdata carries, from bit 0:
//   error_code, error_data, is_raised, force_emit.
// Output stream (m_axis_*): exactly one result per request, in order. tdata
//   carries, from bit 0: emit, out_code, out_data, suppressed, table_full.
//   Tick, clear and reserved kinds answer with an all-zero result.
// Config: cfg_we_i writes cfg_wdata_i into the suppression window (seconds).
//   Write it only while no request is in flight.
// Timing: two register stages. The input register loads at the handshake
//   and the result register loads from it once free, after one pass of CAM
//   match, free-slot pick and window compare. Table and clock update in that
//   same cycle: throughput 1 per cycle while m_axis_tready is high.
// Reset: clears the seconds counter, all slot valid bits and both stage
//   valids; the window returns to 60 s. No clearing pass is needed.
// Back-pressure: when m_axis_tready is low the result register holds; the
//   input register still takes one more request, then s_axis_tready drops
//   until the result is taken.
module error_code_suppression_table #(
  parameter int unsigned CODE_SLOTS = ecst_pkg::CodeSlotsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // suppression window write
  input  logic                           cfg_we_i,
  input  logic [ecst_pkg::WindowW-1:0]   cfg_wdata_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] error_code, [63:32] error_data, [64] is_raised, [65] force_emit
  input  logic [ecst_pkg::InTdataW-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [ecst_pkg::KindW-1:0]     s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] emit, [32:1] out_code, [64:33] out_data, [65] suppressed,
  // [66] table_full
  output logic [ecst_pkg::OutTdataW-1:0] m_axis_tdata
);
  import ecst_pkg::*;

  localparam int unsigned SlotW = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;

  // Stage 1: input register
  logic    s1_valid_q, s1_valid_d;
  in_req_t s1_q;
  // Stage 2: result register
  logic     out_valid_q, out_valid_d;
  out_res_t out_q, out_d;

  // Block state. Only the fields that shape a result are kept per slot:
  // key, valid and time of last update.
  logic [TimeW-1:0]   now_q, now_d;
  logic [WindowW-1:0] window_q;
  logic [CODE_SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic [CodeW-1:0] slot_code_q    [CODE_SLOTS];
  logic [TimeW-1:0] slot_updated_q [CODE_SLOTS];

  logic out_free, s1_adv;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s1_valid_d    = (s_axis_tvalid && s_axis_tready) || (s1_valid_q && !s1_adv);

  // Associative match and free-slot pick (lowest index wins)
  logic             hit, has_free;
  logic [SlotW-1:0] hit_idx, free_idx;
  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CODE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && (slot_code_q[i] == s1_q.code)) begin
        hit     = 1'b1;
        hit_idx = SlotW'(i);
      end
      if (!slot_valid_q[i]) begin
        has_free = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // Window check on the matched slot; a slot last updated at time zero never suppresses
  logic [TimeW-1:0] hit_upd, age;
  logic             in_window;
  assign hit_upd   = slot_updated_q[hit_idx];
  assign age       = now_q - hit_upd;
  assign in_window = hit && (hit_upd != '0) && (age < TimeW'(window_q));

  // Result and state update for the request in stage 1
  logic             wr_en;
  logic [SlotW-1:0] wr_idx;
  always_comb begin
    now_d        = now_q;
    slot_valid_d = slot_valid_q;
    wr_en        = 1'b0;
    wr_idx       = hit ? hit_idx : free_idx;
    out_d        = '0;
    case (kind_e'(s1_q.kind))
      KIND_TICK: begin
        now_d = now_q + TimeW'(1);
      end
      KIND_CLEAR: begin
        slot_valid_d = '0;
      end
      KIND_REPORT: begin
        wr_en            = hit || has_free;
        slot_valid_d[wr_idx] = slot_valid_q[wr_idx] | wr_en;
        out_d.suppressed = !s1_q.force_emit && in_window;
        out_d.table_full = !wr_en;
        out_d.emit       = s1_q.raised && !out_d.suppressed;
        out_d.code       = s1_q.code;
        out_d.data       = s1_q.data;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = s1_adv || (out_valid_q && !m_axis_tready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      now_q        <= '0;
      window_q     <= WindowReset;
      slot_valid_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (s1_adv) begin
        now_q        <= now_d;
        slot_valid_q <= slot_valid_d;
      end
    end
  end

  // Payload registers and slot contents
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_q.kind       <= s_axis_tuser;
      s1_q.code       <= s_axis_tdata[CodeW-1:0];
      s1_q.data       <= s_axis_tdata[CodeW+DataW-1:CodeW];
      s1_q.raised     <= s_axis_tdata[CodeW+DataW];
      s1_q.force_emit <= s_axis_tdata[CodeW+DataW+1];
    end
    if (s1_adv) begin
      out_q <= out_d;
      if (wr_en && kind_e'(s1_q.kind) == KIND_REPORT) begin
        slot_code_q[wr_idx]    <= s1_q.code;
        slot_updated_q[wr_idx] <= now_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (OutTdataW - OutPackW)'(0),
    out_q.table_full, out_q.suppressed, out_q.data, out_q.code, out_q.emit
  };

`ifndef SYNTHESIS
  // A held request in stage 1 is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("stage 1 request lost");

  // Clear empties the table
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_q.kind == KIND_CLEAR) |=> slot_valid_q == '0)
    else $error("table not empty after clear");

  // Tick advances time by exactly one
  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_q.kind == KIND_TICK) |=> now_q == $past(now_q) + TimeW'(1))
    else $error("tick did not advance time");

  // A report that found no slot is never suppressed
  a_full_supp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.table_full |-> !out_q.suppressed)
    else $error("table_full with suppressed");

  // A suppressed report never emits
  a_emit_supp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.suppressed |-> !out_q.emit)
    else $error("emit while suppressed");
`endif

endmodule
